// File: rtl/core/tbprq_pkg.sv
package tbprq_pkg;

	// Default sizes of the queue arrays.
	localparam int LEVELS_DEF      = 10;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 16;

	// Queue index of a level is its priority plus this offset.
	localparam int PRIO_OFFSET = 5;

	// Field widths on the stream ports.
	localparam int MODE_W     = 2;
	localparam int TASK_W     = 16;
	localparam int PRIO_W     = 4;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 3;

	// Request codes carried on the input tuser.
	localparam logic [MODE_W-1:0] MODE_ADD_ACTIVE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_INACTIVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TAKE         = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FETCH
	} state_t;

endpackage

// File: rtl/core/tbprq_ram.sv
module tbprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/tbprq_pick.sv
module tbprq_pick #(
	parameter int LEVELS = tbprq_pkg::LEVELS_DEF
) (
	input  logic [tbprq_pkg::MODE_W-1:0]        mode,
	input  logic signed [tbprq_pkg::PRIO_W-1:0] priority_req,
	input  logic                                bank,
	input  logic [2*LEVELS-1:0]                 nonempty,
	output logic [$clog2(2*LEVELS)-1:0]         q,
	output logic                                found
);
	import tbprq_pkg::*;

	localparam int Q_W   = $clog2(2*LEVELS);
	localparam int LVL_W = $clog2(LEVELS);

	logic [LVL_W-1:0]  add_lvl;
	logic [LVL_W-1:0]  take_lvl;
	logic [LEVELS-1:0] act;
	logic              add_bank;

	// Out-of-range priorities clamp to the first or the last queue.
	always_comb begin
		int p;
		p = int'(priority_req) + PRIO_OFFSET;
		if (p < 0) begin
			p = 0;
		end
		if (p > LEVELS - 1) begin
			p = LEVELS - 1;
		end
		add_lvl = LVL_W'(p);
	end

	assign act = bank ? nonempty[2*LEVELS-1:LEVELS] : nonempty[LEVELS-1:0];

	// Lowest-numbered non-empty queue of the active bank wins.
	always_comb begin
		found    = 1'b0;
		take_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (act[i]) begin
				found    = 1'b1;
				take_lvl = LVL_W'(i);
			end
		end
	end

	assign add_bank = (mode == MODE_ADD_ACTIVE) ? bank : ~bank;

	always_comb begin
		if (mode == MODE_TAKE) begin
			q = bank ? Q_W'(LEVELS) + Q_W'(take_lvl) : Q_W'(take_lvl);
		end else begin
			q = add_bank ? Q_W'(LEVELS) + Q_W'(add_lvl) : Q_W'(add_lvl);
		end
	end

endmodule

// File: rtl/core/two_bank_priority_run_queue.sv
// Two banks of per-priority FIFO run queues with a swap on an empty take. One
// request is handled at a time: an add reads the queue pointer, then writes the
// slot and the pointer back; a take that finds a task reads the pointer, then the
// slot from the task memory, then registers the result; and a take on an empty
// active bank registers its result at once. The pointer memory and the task
// memory both have registered reads, and they lie in series on the take path.
// A request is accepted when the block is idle and its output register is empty
// or handing its result over in the same cycle. No clearing pass runs after
// reset: queue pointers carry a valid bit per queue, and the task memory is only
// read at slots that were written.
module two_bank_priority_run_queue #(
	parameter int LEVELS      = tbprq_pkg::LEVELS_DEF,
	parameter int QUEUE_DEPTH = tbprq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = tbprq_pkg::ID_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// task_id [15:0], priority_req [19:16], zero [23:20]
	input  logic [tbprq_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode [1:0]
	input  logic [tbprq_pkg::MODE_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// task_out [15:0]
	output logic [tbprq_pkg::OUT_DATA_W-1:0] m_tdata,
	// task_valid [0], era_changed [1], overflow [2]
	output logic [tbprq_pkg::OUT_USER_W-1:0] m_tuser
);
	import tbprq_pkg::*;

	localparam int NQ    = 2 * LEVELS;
	localparam int Q_W   = $clog2(NQ);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PE_W  = 2 * PTR_W + CNT_W;
	localparam int NSLOT = NQ * QUEUE_DEPTH;
	localparam int SA_W  = $clog2(NSLOT);

	state_t state_q, state_d;

	logic                     bank_q;
	logic [NQ-1:0]            nonempty_q;
	logic [NQ-1:0]            ptr_vld_q;

	logic                     take_s1;
	logic [Q_W-1:0]           q_s1;
	logic [ID_BITS-1:0]       id_s1;
	logic                     pvld_s1;

	logic                     out_valid_q;
	logic [OUT_DATA_W-1:0]    out_data_q;
	logic [OUT_USER_W-1:0]    out_user_q;

	logic [MODE_W-1:0]        in_mode;
	logic [TASK_W-1:0]        in_id;
	logic signed [PRIO_W-1:0] in_prio;
	logic                     is_add, is_take, acc, go_lookup;

	logic [Q_W-1:0]           q_pick;
	logic                     found;

	logic [PE_W-1:0]          ptr_rd, ent, ptr_wd;
	logic                     ptr_re, ptr_we;
	logic [PTR_W-1:0]         head, tail, head_nx, tail_nx;
	logic [CNT_W-1:0]         cnt;
	logic                     full;

	logic [SA_W-1:0]          slot_addr;
	logic                     st_we, st_re;
	logic [ID_BITS-1:0]       st_rd;

	logic                     ld, ld_valid, ld_era, ld_ovf;

	assign in_mode = s_tuser;
	assign in_id   = s_tdata[TASK_W-1:0];
	assign in_prio = s_tdata[TASK_W +: PRIO_W];

	assign is_add    = (in_mode == MODE_ADD_ACTIVE) || (in_mode == MODE_ADD_INACTIVE);
	assign is_take   = (in_mode == MODE_TAKE);
	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign acc       = s_tvalid && s_tready;
	assign go_lookup = is_add || (is_take && found);

	tbprq_pick #(
		.LEVELS(LEVELS)
	) u_pick (
		.mode        (in_mode),
		.priority_req(in_prio),
		.bank        (bank_q),
		.nonempty    (nonempty_q),
		.q           (q_pick),
		.found       (found)
	);

	tbprq_ram #(
		.WIDTH(PE_W),
		.DEPTH(NQ)
	) u_ptr_ram (
		.clk  (clk),
		.we   (ptr_we),
		.waddr(q_s1),
		.wdata(ptr_wd),
		.re   (ptr_re),
		.raddr(q_pick),
		.rdata(ptr_rd)
	);

	tbprq_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(NSLOT)
	) u_task_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(slot_addr),
		.wdata(id_s1),
		.re   (st_re),
		.raddr(slot_addr),
		.rdata(st_rd)
	);

	// A queue never written since reset reads as all zero.
	assign ent  = pvld_s1 ? ptr_rd : '0;
	assign head = ent[PTR_W-1:0];
	assign tail = ent[2*PTR_W-1:PTR_W];
	assign cnt  = ent[PE_W-1:2*PTR_W];
	assign full = (cnt == CNT_W'(QUEUE_DEPTH));

	assign head_nx = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
	assign tail_nx = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

	assign slot_addr = SA_W'(q_s1) * SA_W'(QUEUE_DEPTH) + SA_W'(take_s1 ? head : tail);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && go_lookup) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = take_s1 ? ST_FETCH : ST_IDLE;
			end
			ST_FETCH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ptr_re   = 1'b0;
		ptr_we   = 1'b0;
		ptr_wd   = '0;
		st_we    = 1'b0;
		st_re    = 1'b0;
		ld       = 1'b0;
		ld_valid = 1'b0;
		ld_era   = 1'b0;
		ld_ovf   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					ptr_re = go_lookup;
					if (!go_lookup) begin
						// Empty-bank take or an unused code finishes at once.
						ld     = 1'b1;
						ld_era = is_take;
					end
				end
			end
			ST_LOOKUP: begin
				if (take_s1) begin
					st_re  = 1'b1;
					ptr_we = 1'b1;
					ptr_wd = {cnt - 1'b1, tail, head_nx};
				end else if (full) begin
					ld     = 1'b1;
					ld_ovf = 1'b1;
				end else begin
					st_we  = 1'b1;
					ptr_we = 1'b1;
					ptr_wd = {cnt + 1'b1, tail_nx, head};
					ld     = 1'b1;
				end
			end
			ST_FETCH: begin
				ld       = 1'b1;
				ld_valid = 1'b1;
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bank_q     <= 1'b0;
			nonempty_q <= '0;
			ptr_vld_q  <= '0;
		end else begin
			state_q <= state_d;
			if (acc && is_take && !found) begin
				bank_q <= ~bank_q;
			end
			if (ptr_we) begin
				ptr_vld_q[q_s1]  <= 1'b1;
				nonempty_q[q_s1] <= take_s1 ? (cnt != CNT_W'(1)) : 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			take_s1 <= is_take;
			q_s1    <= q_pick;
			id_s1   <= ID_BITS'(in_id);
			pvld_s1 <= ptr_vld_q[q_pick];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_data_q <= ld_valid ? OUT_DATA_W'(st_rd) : '0;
			out_user_q <= {ld_ovf, ld_era, ld_valid};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> (!out_valid_q || m_tready))
		else $error("result loaded over an untaken result");

	// A take only goes to memory for a queue marked non-empty.
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && take_s1) |-> nonempty_q[q_s1])
		else $error("take selected an empty queue");

	// The non-empty flags track the stored occupancy.
	a_flag_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |-> (nonempty_q[q_s1] == (cnt != '0)))
		else $error("non-empty flag disagrees with queue count");

	// A fetched slot is delivered as a valid task on the next cycle.
	a_fetch_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (m_tvalid && m_tuser[0]))
		else $error("fetched task not presented");

	// An era change leaves the bank select toggled.
	a_era_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_take && !found) |=> (bank_q != $past(bank_q)))
		else $error("bank select did not toggle on era change");

endmodule

// File: test/run_queue_checker.sv
`timescale 1ns / 100ps

module run_queue_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// task_id [15:0], priority_req [19:16], zero [23:20]
	input  logic [tbprq_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode [1:0]
	input  logic [tbprq_pkg::MODE_W-1:0]     s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// task_out [15:0]
	input  logic [tbprq_pkg::OUT_DATA_W-1:0] m_tdata,
	// task_valid [0], era_changed [1], overflow [2]
	input  logic [tbprq_pkg::OUT_USER_W-1:0] m_tuser,
	output int                               mismatches,
	output int                               pending
);
	import tbprq_pkg::*;

	localparam int NUM_QUEUES = 2 * LEVELS_DEF;

	typedef struct packed {
		logic              task_valid;
		logic [TASK_W-1:0] task_out;
		logic              era_changed;
		logic              overflow;
	} run_result_t;

	logic [TASK_W-1:0] slot_mem [NUM_QUEUES][QUEUE_DEPTH_DEF];
	int                q_head [NUM_QUEUES];
	int                q_tail [NUM_QUEUES];
	int                q_count [NUM_QUEUES];
	logic              second_active;
	run_result_t       expected_results [$];

	assign pending = expected_results.size();

	task automatic report(input string msg);
		$display("%0t checker: %s", $time, msg);
		mismatches++;
	endtask

	// Out-of-range priorities land on the first or the last level.
	function automatic int level_of_priority(input logic signed [PRIO_W-1:0] prio);
		int idx;
		idx = int'(prio) + PRIO_OFFSET;
		if (idx < 0) begin
			idx = 0;
		end
		if (idx > LEVELS_DEF - 1) begin
			idx = LEVELS_DEF - 1;
		end
		return idx;
	endfunction

	function automatic run_result_t schedule_request(input logic [MODE_W-1:0] mode,
			input logic [TASK_W-1:0] id, input logic signed [PRIO_W-1:0] prio);
		run_result_t res;
		int          bank;
		int          q;
		int          lvl;
		bit          found;
		res = '0;
		if (mode == MODE_ADD_ACTIVE || mode == MODE_ADD_INACTIVE) begin
			bank = (mode == MODE_ADD_ACTIVE) ? int'(second_active) : int'(!second_active);
			q = bank * LEVELS_DEF + level_of_priority(prio);
			if (q_count[q] >= QUEUE_DEPTH_DEF) begin
				res.overflow = 1'b1;
			end else begin
				slot_mem[q][q_tail[q]] = id;
				q_tail[q] = (q_tail[q] + 1) % QUEUE_DEPTH_DEF;
				q_count[q]++;
			end
		end else if (mode == MODE_TAKE) begin
			found = 0;
			for (lvl = 0; lvl < LEVELS_DEF && !found; lvl++) begin
				q = int'(second_active) * LEVELS_DEF + lvl;
				if (q_count[q] > 0) begin
					res.task_valid = 1'b1;
					res.task_out = slot_mem[q][q_head[q]];
					q_head[q] = (q_head[q] + 1) % QUEUE_DEPTH_DEF;
					q_count[q]--;
					found = 1;
				end
			end
			// An empty active bank swaps the banks and starts a new era.
			if (!found) begin
				second_active = !second_active;
				res.era_changed = 1'b1;
			end
		end
		return res;
	endfunction

	task automatic check_result();
		run_result_t want;
		if (expected_results.size() == 0) begin
			report($sformatf("result with no request outstanding: tdata %h tuser %b",
				m_tdata, m_tuser));
		end else begin
			want = expected_results.pop_front();
			if (m_tdata !== want.task_out) begin
				report($sformatf("task_out %h, expected %h", m_tdata, want.task_out));
			end
			if (m_tuser[0] !== want.task_valid) begin
				report($sformatf("task_valid %b, expected %b", m_tuser[0], want.task_valid));
			end
			if (m_tuser[1] !== want.era_changed) begin
				report($sformatf("era_changed %b, expected %b", m_tuser[1], want.era_changed));
			end
			if (m_tuser[2] !== want.overflow) begin
				report($sformatf("overflow %b, expected %b", m_tuser[2], want.overflow));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				q_head[i] = 0;
				q_tail[i] = 0;
				q_count[i] = 0;
			end
			second_active = 1'b0;
			expected_results.delete();
		end else begin
			// A result always leaves after its request, so checking first is safe.
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (s_tvalid && s_tready) begin
				expected_results.insert(expected_results.size(),
					schedule_request(s_tuser, s_tdata[15:0], s_tdata[19:16]));
			end
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
	import tbprq_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1550;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	int                    mismatches;
	int                    pending;
	bit                    quiet;
	bit                    long_hold_req;
	int                    idle_cycles;

	two_bank_priority_run_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	run_queue_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [TASK_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input bit drain_first);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (drain_first) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while (pending != 0);
		end else if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, prio, id};
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		int                counted;
		int                phase_len;
		int                kind;
		int                lo;
		int                hi;
		int                roll;
		int                lvl;
		int                i;
		bit                drain;
		logic [MODE_W-1:0] mode;
		logic [TASK_W-1:0] id;
		logic [PRIO_W-1:0] prio;

		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_ADD_ACTIVE;
		arst_n = 1'b0;
		quiet = 0;
		long_hold_req = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Take from an empty bank first, then adds at both ends and beyond the range, a reserved code and takes.
		send_request(MODE_TAKE, 16'h1234, 4'sd0, 0);
		send_request(MODE_ADD_ACTIVE, 16'hFFFF, -4'sd5, 0);
		send_request(MODE_ADD_INACTIVE, 16'h0000, 4'sd4, 0);
		send_request(MODE_ADD_ACTIVE, 16'hA5A5, -4'sd8, 0);
		send_request(MODE_ADD_ACTIVE, 16'h5A5A, 4'sd7, 0);
		send_request(MODE_RESERVED, 16'h1234, 4'sd0, 0);
		send_request(MODE_TAKE, 16'h0000, 4'sd0, 0);
		send_request(MODE_TAKE, 16'hFFFF, 4'sd7, 0);
		send_request(MODE_TAKE, 16'h0000, -4'sd8, 0);
		send_request(MODE_TAKE, 16'h0000, 4'sd0, 0);
		send_request(MODE_TAKE, 16'h0000, 4'sd0, 0);
		// Seventeen adds into one queue: the last one must be dropped.
		for (i = 0; i < QUEUE_DEPTH_DEF + 1; i++) begin
			send_request(MODE_ADD_ACTIVE, TASK_W'(16'h8000 + i), 4'sd0, 0);
		end

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 2);
			phase_len = $urandom_range(20, 80);
			lo = $urandom_range(0, LEVELS_DEF - 1);
			hi = lo + $urandom_range(0, 2);
			if (hi > LEVELS_DEF - 1) begin
				hi = LEVELS_DEF - 1;
			end
			quiet = ($urandom_range(0, 4) == 0);
			drain = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) begin
				long_hold_req = 1;
			end
			// The first phase fills queues against a stalled receiver after a full drain.
			if (counted == 0) begin
				kind = 0;
				drain = 1;
				long_hold_req = 1;
			end
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					mode = MODE_RESERVED;
				end else if (roll < (kind == 0 ? 87 : (kind == 1 ? 17 : 52))) begin
					mode = ($urandom_range(0, 9) < 7) ? MODE_ADD_ACTIVE : MODE_ADD_INACTIVE;
				end else begin
					mode = MODE_TAKE;
				end
				id = TASK_W'($urandom_range(0, 65535));
				if ($urandom_range(0, 9) == 0) begin
					prio = PRIO_W'($urandom_range(0, 15));
				end else begin
					lvl = $urandom_range(lo, hi);
					prio = PRIO_W'(lvl - PRIO_OFFSET);
				end
				send_request(mode, id, prio, drain);
				drain = 0;
				if (mode != MODE_RESERVED) begin
					counted++;
				end
			end
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (12) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Result side: random stalls per transaction, plus a long hold when asked.
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold_req = 0;
			end else begin
				gap = quiet ? 0 : $urandom_range(0, 9);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				m_tready <= 1'b1;
				do @(posedge clk); while (!m_tvalid);
				@(negedge clk);
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("tb: failure");
		$finish;
	end

endmodule
